// ----- rtl/fac_pkg.sv -----
// Shared types and constants for the frustum box culling block.
// Used by fac_plane_cell, frustum_aabb_cull and fac_checker; no dependencies.

package fac_pkg;

   // Matrix words are signed fixed point; a plane component is the sum or
   // difference of two of them and needs one more bit.
   localparam int MAT_WIDTH   = 32;
   localparam int PLANE_WIDTH = MAT_WIDTH + 1;
   localparam int MAT_DIM     = 4;
   localparam int NUM_AXES    = 3;
   localparam int NUM_PLANES  = 6;
   localparam int W_INDEX     = 3;    // column and row index of the w terms

   localparam int DEF_COORD_WIDTH = 32;
   localparam int DEF_FRAC_BITS   = 16;

   localparam int CFG_DATA_WIDTH  = 2 * MAT_WIDTH;
   localparam int NUM_CFG_REGS    = 8;
   localparam int CFG_INDEX_WIDTH = $clog2(NUM_CFG_REGS);

   // Input register plus two stages in each plane cell.
   localparam int LATENCY = 1 + 2 * NUM_PLANES;

   // Indexed [column][row].
   typedef logic [MAT_DIM-1:0][MAT_DIM-1:0][MAT_WIDTH-1:0] matrix_type;

   typedef struct packed {
      logic valid;
      logic visible;
   } tag_type;

endpackage

// ----- rtl/frustum_aabb_cull.sv -----
// Frustum culling of axis-aligned boxes against six planes from a 4x4 matrix.
// A start transfer enters the input register, then both stages of each plane cell.
// Throughput: one box per cycle; the six plane cells form a two-stage-per-cell chain.
// Reset (synchronous) clears the matrix to zero and empties the chain; busy is
// high only while reset is. Results cannot be stalled by the receiver.

module frustum_aabb_cull #(
   parameter int COORD_WIDTH = fac_pkg::DEF_COORD_WIDTH,
   parameter int FRAC_BITS   = fac_pkg::DEF_FRAC_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic signed [COORD_WIDTH-1:0]          req_min_x,
   input  logic signed [COORD_WIDTH-1:0]          req_min_y,
   input  logic signed [COORD_WIDTH-1:0]          req_min_z,
   input  logic signed [COORD_WIDTH-1:0]          req_max_x,
   input  logic signed [COORD_WIDTH-1:0]          req_max_y,
   input  logic signed [COORD_WIDTH-1:0]          req_max_z,
   output logic                                   rsp_valid,
   output logic                                   rsp_visible,
   input  logic                                   csr_we,
   input  logic [fac_pkg::CFG_INDEX_WIDTH-1:0]    csr_index,
   input  logic [fac_pkg::CFG_DATA_WIDTH-1:0]     csr_wdata
);
   import fac_pkg::*;

   logic [CFG_DATA_WIDTH-1:0] cfg_ff [NUM_CFG_REGS];
   matrix_type                matrix;

   logic    accept;
   tag_type tag_in;
   tag_type tag [NUM_PLANES+1];
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_lo [NUM_PLANES];
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] box_hi [NUM_PLANES];

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CFG_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   // Each register holds two rows of one column, the lower row in the low half.
   for (genvar c = 0; c < MAT_DIM; c++) begin : g_col
      for (genvar r = 0; r < MAT_DIM; r++) begin : g_row
         assign matrix[c][r] = cfg_ff[c * 2 + r / 2][(r % 2) * MAT_WIDTH +: MAT_WIDTH];
      end
   end

   always_comb begin
      tag_in.valid   = accept;
      tag_in.visible = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag[0] <= '0;
      end else begin
         tag[0] <= tag_in;
      end
      if (accept) begin
         box_lo[0] <= {req_min_z, req_min_y, req_min_x};
         box_hi[0] <= {req_max_z, req_max_y, req_max_x};
      end
   end

   // Planes in order left, right, bottom, top, near, far.
   for (genvar k = 0; k < NUM_PLANES; k++) begin : g_plane
      if (k < NUM_PLANES - 1) begin : g_mid
         fac_plane_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .PLANE_ROW   (k / 2),
            .PLANE_SUB   ((k % 2) != 0)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .matrix  (matrix),
            .in_tag  (tag[k]),
            .in_lo   (box_lo[k]),
            .in_hi   (box_hi[k]),
            .out_tag (tag[k+1]),
            .out_lo  (box_lo[k+1]),
            .out_hi  (box_hi[k+1])
         );
      end else begin : g_last
         fac_plane_cell #(
            .COORD_WIDTH (COORD_WIDTH),
            .FRAC_BITS   (FRAC_BITS),
            .PLANE_ROW   (k / 2),
            .PLANE_SUB   ((k % 2) != 0)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .matrix  (matrix),
            .in_tag  (tag[k]),
            .in_lo   (box_lo[k]),
            .in_hi   (box_hi[k]),
            .out_tag (tag[k+1]),
            .out_lo  (),
            .out_hi  ()
         );
      end
   end

   assign rsp_valid   = tag[NUM_PLANES].valid;
   assign rsp_visible = tag[NUM_PLANES].visible;

endmodule

// ----- rtl/fac_plane_cell.sv -----
// One plane test of the culling chain: corner select and multiply, then sum
// and sign check. Boxes pass through stages A and B. Depends on fac_pkg.

module fac_plane_cell #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   parameter int PLANE_ROW   = 0,
   parameter bit PLANE_SUB   = 1'b0
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  fac_pkg::matrix_type                            matrix,
   input  fac_pkg::tag_type                               in_tag,
   input  logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  in_lo,
   input  logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  in_hi,
   output fac_pkg::tag_type                               out_tag,
   output logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  out_lo,
   output logic [fac_pkg::NUM_AXES-1:0][COORD_WIDTH-1:0]  out_hi
);
   import fac_pkg::*;

   localparam int PROD_WIDTH = PLANE_WIDTH + COORD_WIDTH;
   localparam int DIST_WIDTH = PLANE_WIDTH + FRAC_BITS;
   localparam int TERM_WIDTH = (PROD_WIDTH > DIST_WIDTH) ? PROD_WIDTH : DIST_WIDTH;
   localparam int SUM_WIDTH  = TERM_WIDTH + 2;

   logic signed [PLANE_WIDTH-1:0] normal_in [NUM_AXES];
   logic signed [PLANE_WIDTH-1:0] normal_ff [NUM_AXES];
   logic signed [PLANE_WIDTH-1:0] dist_in;
   logic signed [PLANE_WIDTH-1:0] dist_ff;
   logic signed [PLANE_WIDTH-1:0] w_term [MAT_DIM];
   logic signed [PLANE_WIDTH-1:0] r_term [MAT_DIM];

   logic signed [COORD_WIDTH-1:0] corner [NUM_AXES];
   logic signed [PROD_WIDTH-1:0]  prod_in [NUM_AXES];
   logic signed [PROD_WIDTH-1:0]  prod_ff [NUM_AXES];
   tag_type                       tag_a_ff;
   tag_type                       tag_b_in;
   tag_type                       tag_b_ff;
   logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_a_ff, hi_a_ff, lo_b_ff, hi_b_ff;

   logic [SUM_WIDTH-1:0] sum;
   logic                 culled;

   // Plane coefficients: w row plus or minus the selected row, per column.
   always_comb begin
      for (int c = 0; c < MAT_DIM; c++) begin
         w_term[c] = $signed({matrix[c][W_INDEX][MAT_WIDTH-1], matrix[c][W_INDEX]});
         r_term[c] = $signed({matrix[c][PLANE_ROW][MAT_WIDTH-1], matrix[c][PLANE_ROW]});
      end
      for (int c = 0; c < NUM_AXES; c++) begin
         normal_in[c] = PLANE_SUB ? (w_term[c] - r_term[c]) : (w_term[c] + r_term[c]);
      end
      dist_in = PLANE_SUB ? (w_term[W_INDEX] - r_term[W_INDEX])
                          : (w_term[W_INDEX] + r_term[W_INDEX]);
   end

   always_ff @(posedge clock) begin
      normal_ff <= normal_in;
      dist_ff   <= dist_in;
   end

   // Stage A: the corner farthest along the normal, times the normal.
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         corner[c]  = (normal_ff[c] > 0) ? $signed(in_hi[c]) : $signed(in_lo[c]);
         prod_in[c] = normal_ff[c] * corner[c];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
      end else begin
         tag_a_ff <= in_tag;
      end
      prod_ff <= prod_in;
      lo_a_ff <= in_lo;
      hi_a_ff <= in_hi;
   end

   // Stage B: exact sum of the three products and the aligned distance.
   always_comb begin
      sum = {{(SUM_WIDTH-PROD_WIDTH){prod_ff[0][PROD_WIDTH-1]}}, prod_ff[0]}
          + {{(SUM_WIDTH-PROD_WIDTH){prod_ff[1][PROD_WIDTH-1]}}, prod_ff[1]}
          + {{(SUM_WIDTH-PROD_WIDTH){prod_ff[2][PROD_WIDTH-1]}}, prod_ff[2]}
          + {{(SUM_WIDTH-DIST_WIDTH){dist_ff[PLANE_WIDTH-1]}}, dist_ff,
             {FRAC_BITS{1'b0}}};
      culled = sum[SUM_WIDTH-1];
      tag_b_in.valid   = tag_a_ff.valid;
      tag_b_in.visible = tag_a_ff.visible & ~culled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_b_ff <= '0;
      end else begin
         tag_b_ff <= tag_b_in;
      end
      lo_b_ff <= lo_a_ff;
      hi_b_ff <= hi_a_ff;
   end

   assign out_tag = tag_b_ff;
   assign out_lo  = lo_b_ff;
   assign out_hi  = hi_b_ff;

endmodule

// ----- rtl/fac_checker.sv -----
// Port-level checks for frustum_aabb_cull, attached to it by a bind statement.
// Depends on fac_pkg for the pipeline latency.

module fac_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);
   import fac_pkg::*;

   // Every accepted box gives exactly one result after the fixed latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_valid)
      else $error("accepted box produced no result at the expected cycle");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result strobe without a matching transfer");

   // Reset empties the chain.
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind frustum_aabb_cull fac_checker u_fac_checker (.*);

// ----- verif/frustum_aabb_cull_tb.sv -----
// Self-checking testbench for frustum_aabb_cull: boxes are tested against matrices written
// through the csr port, and every rsp_visible strobe is compared with a predicted result.
// Depends on rtl/fac_pkg.sv and rtl/frustum_aabb_cull.sv.
`timescale 1ns / 1ps

module frustum_aabb_cull_tb;

   localparam int CW     = fac_pkg::DEF_COORD_WIDTH;
   localparam int FB     = fac_pkg::DEF_FRAC_BITS;
   localparam int MW     = fac_pkg::MAT_WIDTH;
   localparam int IW     = fac_pkg::CFG_INDEX_WIDTH;
   localparam int Q_ONE  = 1 << FB;
   localparam int PHASES = 20;
   localparam int PHASE_ITEMS = 50;

   localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [MW-1:0] W_MAX = {1'b0, {(MW-1){1'b1}}};
   localparam logic [MW-1:0] W_MIN = {1'b1, {(MW-1){1'b0}}};

   typedef enum logic [IW-1:0] {
      REG_COL0_ROWS_0_1, REG_COL0_ROWS_2_3, REG_COL1_ROWS_0_1, REG_COL1_ROWS_2_3,
      REG_COL2_ROWS_0_1, REG_COL2_ROWS_2_3, REG_COL3_ROWS_0_1, REG_COL3_ROWS_2_3
   } reg_index_type;

   typedef enum int {MAT_ZERO, MAT_PERSP, MAT_SMALL, MAT_WIDE, MAT_EXTREME} matrix_kind_type;
   typedef enum int {BOX_SCENE, BOX_INVERTED, BOX_WIDE, BOX_EXTREME} box_kind_type;

   // Axis 0 is x, 1 is y, 2 is z.
   typedef struct packed {
      logic [2:0][CW-1:0] lo;
      logic [2:0][CW-1:0] hi;
   } box_type;

   class cull_scoreboard_type;
      logic [2*MW-1:0] mat_regs [8];
      bit              visible_q [$];
      int              errors;

      function new();
         foreach (mat_regs[i]) mat_regs[i] = '0;
         errors = 0;
      endfunction

      function void write_reg(int idx, logic [2*MW-1:0] val);
         if (idx < 8) mat_regs[idx] = val;
      endfunction

      function longint mat_word(int col, int row);
         logic signed [MW-1:0] w;
         w = mat_regs[col * 2 + row / 2][MW * (row % 2) +: MW];
         return w;
      endfunction

      // Exact plane sums in 128 bits; any negative sum culls the box.
      function bit predict_visible(box_type b);
         longint               plane_d;
         longint               n;
         longint               corner;
         logic signed [127:0]  acc;
         logic signed [127:0]  nw;
         logic signed [127:0]  cw;
         int                   row;
         bit                   vis;
         vis = 1'b1;
         for (int k = 0; k < fac_pkg::NUM_PLANES; k++) begin
            row = k / 2;
            if (k % 2) plane_d = mat_word(3, 3) - mat_word(3, row);
            else       plane_d = mat_word(3, 3) + mat_word(3, row);
            acc = plane_d;
            acc = acc <<< FB;
            for (int c = 0; c < fac_pkg::NUM_AXES; c++) begin
               if (k % 2) n = mat_word(c, 3) - mat_word(c, row);
               else       n = mat_word(c, 3) + mat_word(c, row);
               corner = (n > 0) ? $signed(b.hi[c]) : $signed(b.lo[c]);
               nw = n;
               cw = corner;
               acc = acc + nw * cw;
            end
            if (acc < 0) vis = 1'b0;
         end
         return vis;
      endfunction

      function void note_box(box_type b);
         visible_q.push_back(predict_visible(b));
      endfunction

      function void check_visible(logic got);
         bit want;
         if (visible_q.size() == 0) begin
            if (errors < 10) $display("%0t: rsp_visible=%b with no box in flight", $time, got);
            errors++;
         end else begin
            want = visible_q.pop_front();
            if (got !== want) begin
               if (errors < 10)
                  $display("%0t: rsp_visible mismatch, expected %b, got %b", $time, want, got);
               errors++;
            end
         end
      endfunction

      function int pending();
         return visible_q.size();
      endfunction
   endclass

   logic            clock;
   logic            reset;
   logic            start;
   logic            busy;
   box_type         drv_box;
   logic            rsp_valid;
   logic            rsp_visible;
   logic            csr_we;
   logic [IW-1:0]   csr_index;
   logic [2*MW-1:0] csr_wdata;

   logic signed [MW-1:0] mat_words [4][4];   // [column][row]
   cull_scoreboard_type  sb;

   frustum_aabb_cull uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_min_x   (drv_box.lo[0]),
      .req_min_y   (drv_box.lo[1]),
      .req_min_z   (drv_box.lo[2]),
      .req_max_x   (drv_box.hi[0]),
      .req_max_y   (drv_box.hi[1]),
      .req_max_z   (drv_box.hi[2]),
      .rsp_valid   (rsp_valid),
      .rsp_visible (rsp_visible),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("frustum_aabb_cull_tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) sb.note_box(drv_box);
         if (rsp_valid) sb.check_visible(rsp_visible);
      end
   end

   function automatic logic [MW-1:0] extreme_word();
      case ($urandom_range(0, 4))
         0:       return W_MIN;
         1:       return W_MAX;
         2:       return '0;
         3:       return '1;
         default: return 1;
      endcase
   endfunction

   function automatic box_type box_of(int mnx, int mny, int mnz, int mxx, int mxy, int mxz);
      box_type b;
      b.lo[0] = mnx; b.lo[1] = mny; b.lo[2] = mnz;
      b.hi[0] = mxx; b.hi[1] = mxy; b.hi[2] = mxz;
      return b;
   endfunction

   function automatic box_type make_box(box_kind_type kind);
      box_type b;
      int      ctr;
      int      half;
      int      swap_axis;
      swap_axis = $urandom_range(0, 2);
      for (int c = 0; c < 3; c++) begin
         case (kind)
            BOX_SCENE, BOX_INVERTED: begin
               ctr  = $urandom_range(0, 40 * Q_ONE) - 20 * Q_ONE;
               half = $urandom_range(0, 4 * Q_ONE);
               if (kind == BOX_INVERTED && (c == swap_axis || $urandom_range(0, 1))) begin
                  b.lo[c] = ctr + half;
                  b.hi[c] = ctr - half;
               end else begin
                  b.lo[c] = ctr - half;
                  b.hi[c] = ctr + half;
               end
            end
            BOX_WIDE: begin
               b.lo[c] = $urandom;
               b.hi[c] = $urandom;
            end
            default: begin
               b.lo[c] = extreme_word();
               b.hi[c] = extreme_word();
            end
         endcase
      end
      return b;
   endfunction

   function automatic void make_matrix(matrix_kind_type kind);
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            case (kind)
               MAT_SMALL:   mat_words[c][r] = ($urandom_range(0, 3) == 0) ? 0 :
                                              $urandom_range(0, 4 * Q_ONE) - 2 * Q_ONE;
               MAT_WIDE:    mat_words[c][r] = $urandom;
               MAT_EXTREME: mat_words[c][r] = extreme_word();
               default:     mat_words[c][r] = 0;
            endcase
      if (kind == MAT_PERSP) begin
         // Projection looking down -z, with some skew now and then.
         if ($urandom_range(0, 1))
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++)
                  mat_words[c][r] = $urandom_range(0, Q_ONE / 2) - Q_ONE / 4;
         mat_words[0][0] = $urandom_range(Q_ONE / 2, 3 * Q_ONE);
         mat_words[1][1] = $urandom_range(Q_ONE / 2, 3 * Q_ONE);
         mat_words[2][2] = -$urandom_range(Q_ONE, 2 * Q_ONE);
         mat_words[3][2] = -$urandom_range(0, 4 * Q_ONE);
         mat_words[2][3] = -Q_ONE;
         mat_words[3][0] = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
         mat_words[3][1] = $urandom_range(0, 2 * Q_ONE) - Q_ONE;
         mat_words[3][3] = 0;
      end
   endfunction

   // Writes all eight registers back to back; only called with nothing in flight.
   task automatic load_matrix();
      reg_index_type ri;
      int            col;
      int            row;
      ri = ri.first();
      do begin
         col = int'(ri) / 2;
         row = 2 * (int'(ri) % 2);
         @(negedge clock);
         csr_we    = 1'b1;
         csr_index = ri;
         csr_wdata = {mat_words[col][row + 1], mat_words[col][row]};
         sb.write_reg(int'(ri), csr_wdata);
         ri = ri.next();
      end while (ri != ri.first());
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_box(box_type b, int gap);
      repeat (gap) begin
         @(negedge clock);
         start = 1'b0;
      end
      @(negedge clock);
      start   = 1'b1;
      drv_box = b;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and wait until every predicted result has been checked.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (fac_pkg::LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      matrix_kind_type mk;
      box_kind_type    bk;
      int              pick;
      bit              burst;

      sb        = new();
      reset     = 1'b1;
      start     = 1'b0;
      drv_box   = '0;
      csr_we    = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Zero matrix straight out of reset: every box must come back visible.
      send_box(box_of(0, 0, 0, 0, 0, 0), 0);
      send_box(box_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 0);
      send_box(box_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 3);
      send_box(box_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0);
      send_box(box_of(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 1);
      send_box(box_of(C_MIN, C_MAX, 0, C_MAX, C_MIN, -1), 0);
      settle();

      // Fixed projection, near about 1 and far about 100. Its side planes have
      // zero normal components, so the min corner is taken on those axes.
      make_matrix(MAT_ZERO);
      mat_words[0][0] = Q_ONE;
      mat_words[1][1] = Q_ONE;
      mat_words[2][2] = -66860;
      mat_words[3][2] = -132396;
      mat_words[2][3] = -Q_ONE;
      load_matrix();
      send_box(box_of(-Q_ONE, -Q_ONE, -11 * Q_ONE, Q_ONE, Q_ONE, -9 * Q_ONE), 0);
      send_box(box_of(-Q_ONE, -Q_ONE, 5 * Q_ONE, Q_ONE, Q_ONE, 10 * Q_ONE), 0);
      send_box(box_of(-100 * Q_ONE, 0, -11 * Q_ONE, -90 * Q_ONE, Q_ONE, -9 * Q_ONE), 2);
      send_box(box_of(0, 0, -200 * Q_ONE, Q_ONE, Q_ONE, -150 * Q_ONE), 0);
      send_box(box_of(0, 0, -5 * Q_ONE, 0, 0, -5 * Q_ONE), 0);
      send_box(box_of(Q_ONE, Q_ONE, -9 * Q_ONE, -Q_ONE, -Q_ONE, -11 * Q_ONE), 5);
      send_box(box_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0);
      send_box(box_of(-Q_ONE, -Q_ONE, -2 * Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE), 0);
      settle();

      // Every matrix word at its most negative, then at its most positive.
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            mat_words[c][r] = W_MIN;
      load_matrix();
      send_box(box_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0);
      send_box(box_of(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX), 0);
      send_box(box_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 1);
      settle();
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            mat_words[c][r] = W_MAX;
      load_matrix();
      send_box(box_of(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX), 0);
      send_box(box_of(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN), 0);
      send_box(box_of(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN), 0);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      mk = MAT_PERSP;
         else if (pick < 65) mk = MAT_SMALL;
         else if (pick < 80) mk = MAT_WIDE;
         else if (pick < 90) mk = MAT_EXTREME;
         else                mk = MAT_ZERO;
         make_matrix(mk);
         load_matrix();
         // About a third of the phases run with a transfer on every cycle.
         burst = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      bk = BOX_SCENE;
            else if (pick < 70) bk = BOX_INVERTED;
            else if (pick < 90) bk = BOX_WIDE;
            else                bk = BOX_EXTREME;
            send_box(make_box(bk), burst ? 0 : $urandom_range(0, 14));
         end
         settle();
      end

      if (sb.errors == 0)
         $display("frustum_aabb_cull_tb: done, clean");
      else
         $display("frustum_aabb_cull_tb: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/fac_pkg.sv
rtl/fac_plane_cell.sv
rtl/frustum_aabb_cull.sv
rtl/fac_checker.sv
verif/frustum_aabb_cull_tb.sv
